// ===== design/iau_pkg.sv =====
// Shared types and constants of the interval arithmetic unit.
package iau_pkg;

    localparam int Q_W    = 32;
    localparam int CMD_W  = 3;
    localparam int EXP_W  = 4;
    localparam int PROD_W = 2 * Q_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_MEET = 3'd3,
        CMD_JOIN = 3'd4,
        CMD_NEG  = 3'd5,
        CMD_ABS  = 3'd6,
        CMD_POW  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_MUL,
        S_FOLD,
        S_SAT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       op_en;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       fold_en;
        logic       fold_init;
        logic       sat_en;
        logic       out_en;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic a_empty;
        logic b_empty;
        logic cnt_zero;
        logic cnt_last;
    } t_dp_sts;

endpackage

// ===== design/iau_if.sv =====
// Item channels of the interval arithmetic unit: operand side and result side.
interface iau_in_if;
    logic                             valid;
    logic                             ready;
    logic [iau_pkg::CMD_W-1:0]        command;
    logic signed [iau_pkg::Q_W-1:0]   a_low;
    logic signed [iau_pkg::Q_W-1:0]   a_high;
    logic                             a_empty;
    logic signed [iau_pkg::Q_W-1:0]   b_low;
    logic signed [iau_pkg::Q_W-1:0]   b_high;
    logic                             b_empty;
    logic [iau_pkg::EXP_W-1:0]        exponent;

    modport source (output valid, command, a_low, a_high, a_empty, b_low, b_high, b_empty,
                    exponent, input ready);
    modport sink (input valid, command, a_low, a_high, a_empty, b_low, b_high, b_empty,
                  exponent, output ready);
endinterface

interface iau_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [iau_pkg::Q_W-1:0]   res_low;
    logic signed [iau_pkg::Q_W-1:0]   res_high;
    logic                             res_empty;
    logic                             overflow;

    modport source (output valid, res_low, res_high, res_empty, overflow, input ready);
    modport sink (input valid, res_low, res_high, res_empty, overflow, output ready);
endinterface

// ===== design/iau_ctrl.sv =====
// Controller of the interval arithmetic unit: sequencing and handshakes.
module iau_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output iau_pkg::t_dp_cmd o_cmd,
    input  iau_pkg::t_dp_sts i_sts
);
    import iau_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_OP;
                end
            end
            S_OP: begin
                o_cmd.op_en = 1'b1;
                n_state     = S_OUT;
                n_idx       = '0;
                if (i_sts.cmd == CMD_MUL && !i_sts.a_empty && !i_sts.b_empty) begin
                    n_state = S_MUL;
                end
                if (i_sts.cmd == CMD_POW && !i_sts.a_empty && !i_sts.cnt_zero) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // issue product idx, fold the one issued in the previous cycle
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = r_idx;
                o_cmd.fold_en   = (r_idx != '0);
                o_cmd.fold_init = (r_idx == 2'd1);
                n_idx           = r_idx + 2'd1;
                if (r_idx == '1) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold_en = 1'b1;
                n_state       = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat_en = 1'b1;
                n_idx        = '0;
                if (i_sts.cmd == CMD_POW && !i_sts.cnt_last) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_en = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_to_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_OP))
        else $error("accepted item did not enter operation state");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.out_en)
        else $error("pending result overwritten");
    a_mul_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_MUL) |-> (r_idx == '0))
        else $error("product sequence entered mid-way");
    a_fold_then_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |=> (r_state == S_SAT))
        else $error("fold not followed by saturation");
`endif

endmodule

// ===== design/iau_dp.sv =====
// Datapath of the interval arithmetic unit: operand registers, shared multiplier, min/max fold.
module iau_dp #(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_EXPONENT = 15
) (
    input  logic                             i_clk,
    input  iau_pkg::t_dp_cmd                 i_cmd,
    output iau_pkg::t_dp_sts                 o_sts,
    input  logic [iau_pkg::CMD_W-1:0]        i_command,
    input  logic signed [iau_pkg::Q_W-1:0]   i_a_low,
    input  logic signed [iau_pkg::Q_W-1:0]   i_a_high,
    input  logic                             i_a_empty,
    input  logic signed [iau_pkg::Q_W-1:0]   i_b_low,
    input  logic signed [iau_pkg::Q_W-1:0]   i_b_high,
    input  logic                             i_b_empty,
    input  logic [iau_pkg::EXP_W-1:0]        i_exponent,
    output logic signed [iau_pkg::Q_W-1:0]   o_res_low,
    output logic signed [iau_pkg::Q_W-1:0]   o_res_high,
    output logic                             o_res_empty,
    output logic                             o_overflow
);
    import iau_pkg::*;

    localparam int RW = PROD_W - FRAC_BITS;
    localparam logic signed [Q_W-1:0]    Q_MAX    = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0]    Q_MIN    = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0]    ONE      = Q_W'(64'sd1 << FRAC_BITS);
    localparam logic signed [PROD_W-1:0] RND_MASK = (64'sd1 << FRAC_BITS) - 64'sd1;
    localparam logic signed [RW-1:0]     MAX_RW   = RW'(64'sd2147483647);
    localparam logic signed [RW-1:0]     MIN_RW   = RW'(-64'sd2147483648);

    t_cmd                     r_cmd;
    logic signed [Q_W-1:0]    r_x_lo, r_x_hi, r_y_lo, r_y_hi;
    logic                     r_a_emp, r_b_emp, r_empty, r_ovf;
    logic [EXP_W-1:0]         r_cnt;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RW-1:0]     r_mn, r_mx;
    logic signed [Q_W-1:0]    r_res_lo, r_res_hi;
    logic                     r_res_empty, r_res_ovf;

    logic signed [Q_W-1:0]    a_lo_s, a_hi_s, b_lo_s, b_hi_s;
    logic [EXP_W-1:0]         k_clamp;
    logic signed [Q_W:0]      xl, xh, yl, yh, op_lo, op_hi;
    logic                     op_empty, op_ovf_lo, op_ovf_hi;
    logic signed [Q_W-1:0]    op_lo_sat, op_hi_sat;
    logic signed [Q_W-1:0]    m_a, m_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [RW-1:0]     fl, cl;
    logic signed [Q_W-1:0]    mn_sat, mx_sat;
    logic                     mn_ovf, mx_ovf;

    // swap reversed bounds on entry
    assign a_lo_s  = (i_a_low > i_a_high) ? i_a_high : i_a_low;
    assign a_hi_s  = (i_a_low > i_a_high) ? i_a_low  : i_a_high;
    assign b_lo_s  = (i_b_low > i_b_high) ? i_b_high : i_b_low;
    assign b_hi_s  = (i_b_low > i_b_high) ? i_b_low  : i_b_high;
    assign k_clamp = (int'(i_exponent) > MAX_EXPONENT) ? EXP_W'(MAX_EXPONENT) : i_exponent;

    assign xl = {r_x_lo[Q_W-1], r_x_lo};
    assign xh = {r_x_hi[Q_W-1], r_x_hi};
    assign yl = {r_y_lo[Q_W-1], r_y_lo};
    assign yh = {r_y_hi[Q_W-1], r_y_hi};

    // commands computed directly in the operation state; multiply and power leave x untouched here
    always_comb begin
        op_lo    = xl;
        op_hi    = xh;
        op_empty = 1'b0;
        case (r_cmd)
            CMD_ADD: begin
                op_empty = r_a_emp || r_b_emp;
                op_lo    = xl + yl;
                op_hi    = xh + yh;
            end
            CMD_SUB: begin
                op_empty = r_a_emp || r_b_emp;
                op_lo    = xl - yh;
                op_hi    = xh - yl;
            end
            CMD_MUL: begin
                op_empty = r_a_emp || r_b_emp;
            end
            CMD_MEET: begin
                op_empty = r_a_emp || r_b_emp || (r_x_lo > r_y_hi) || (r_y_lo > r_x_hi);
                op_lo    = (xl > yl) ? xl : yl;
                op_hi    = (xh < yh) ? xh : yh;
            end
            CMD_JOIN: begin
                op_empty = r_a_emp && r_b_emp;
                if (r_a_emp) begin
                    op_lo = yl;
                    op_hi = yh;
                end else if (!r_b_emp) begin
                    op_lo = (xl < yl) ? xl : yl;
                    op_hi = (xh > yh) ? xh : yh;
                end
            end
            CMD_NEG: begin
                op_empty = r_a_emp;
                op_lo    = -xh;
                op_hi    = -xl;
            end
            CMD_ABS: begin
                op_empty = r_a_emp;
                if (r_x_hi < 0) begin
                    op_lo = -xh;
                    op_hi = -xl;
                end else if (r_x_lo <= 0) begin
                    op_lo = '0;
                    op_hi = (-xl > xh) ? -xl : xh;
                end
            end
            CMD_POW: begin
                op_empty = r_a_emp;
            end
            default: begin
                op_empty = 1'b0;
            end
        endcase
    end

    assign op_ovf_lo = op_lo[Q_W] ^ op_lo[Q_W-1];
    assign op_ovf_hi = op_hi[Q_W] ^ op_hi[Q_W-1];
    assign op_lo_sat = op_ovf_lo ? (op_lo[Q_W] ? Q_MIN : Q_MAX) : op_lo[Q_W-1:0];
    assign op_hi_sat = op_ovf_hi ? (op_hi[Q_W] ? Q_MIN : Q_MAX) : op_hi[Q_W-1:0];

    // one shared multiplier, bound pair picked by the product index
    assign m_a   = i_cmd.mul_sel[1] ? r_x_hi : r_x_lo;
    assign m_b   = i_cmd.mul_sel[0] ? r_y_hi : r_y_lo;
    assign mul_p = m_a * m_b;

    // floor for the lower bound, ceiling for the upper bound
    assign fl = RW'(r_prod >>> FRAC_BITS);
    assign cl = RW'((r_prod + RND_MASK) >>> FRAC_BITS);

    assign mn_ovf = (r_mn > MAX_RW) || (r_mn < MIN_RW);
    assign mx_ovf = (r_mx > MAX_RW) || (r_mx < MIN_RW);
    assign mn_sat = (r_mn > MAX_RW) ? Q_MAX : ((r_mn < MIN_RW) ? Q_MIN : Q_W'(r_mn));
    assign mx_sat = (r_mx > MAX_RW) ? Q_MAX : ((r_mx < MIN_RW) ? Q_MIN : Q_W'(r_mx));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= t_cmd'(i_command);
            r_a_emp <= i_a_empty;
            r_b_emp <= i_b_empty;
            r_cnt   <= k_clamp;
            r_ovf   <= 1'b0;
            r_empty <= 1'b0;
            if (t_cmd'(i_command) == CMD_POW) begin
                r_x_lo <= ONE;
                r_x_hi <= ONE;
                r_y_lo <= a_lo_s;
                r_y_hi <= a_hi_s;
            end else begin
                r_x_lo <= a_lo_s;
                r_x_hi <= a_hi_s;
                r_y_lo <= b_lo_s;
                r_y_hi <= b_hi_s;
            end
        end
        if (i_cmd.op_en) begin
            r_x_lo  <= op_lo_sat;
            r_x_hi  <= op_hi_sat;
            r_empty <= op_empty;
            r_ovf   <= op_ovf_lo || op_ovf_hi;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.fold_en) begin
            if (i_cmd.fold_init) begin
                r_mn <= fl;
                r_mx <= cl;
            end else begin
                r_mn <= (fl < r_mn) ? fl : r_mn;
                r_mx <= (cl > r_mx) ? cl : r_mx;
            end
        end
        if (i_cmd.sat_en) begin
            r_x_lo <= mn_sat;
            r_x_hi <= mx_sat;
            r_ovf  <= r_ovf || mn_ovf || mx_ovf;
            r_cnt  <= r_cnt - EXP_W'(1);
        end
        if (i_cmd.out_en) begin
            r_res_lo    <= r_empty ? '0 : r_x_lo;
            r_res_hi    <= r_empty ? '0 : r_x_hi;
            r_res_empty <= r_empty;
            r_res_ovf   <= !r_empty && r_ovf;
        end
    end

    assign o_sts.cmd      = r_cmd;
    assign o_sts.a_empty  = r_a_emp;
    assign o_sts.b_empty  = r_b_emp;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_last = (r_cnt == EXP_W'(1));

    assign o_res_low   = r_res_lo;
    assign o_res_high  = r_res_hi;
    assign o_res_empty = r_res_empty;
    assign o_overflow  = r_res_ovf;

endmodule

// ===== design/interval_arithmetic_unit.sv =====
// Top level of the interval arithmetic unit: controller, datapath and item channels.
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    command, a_low, a_high, a_empty, b_low, b_high, b_empty, exponent
//  o_out    out  valid/ready    res_low, res_high, res_empty, overflow
//
// Add, sub, meet, join, negate, abs: accept, compute, write result.
// Multiply: four bound products go one per cycle through a single 32x32 multiplier,
// then fold and saturate. Power by k: k rounds of multiply, fold, saturate (k clamped).
// Synchronous active-low reset clears the controller; there is no clearing pass.
// A result waits in the output register; the next item is accepted meanwhile and
// stalls only when its own result is ready and the output is still held.
module interval_arithmetic_unit #(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_EXPONENT = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    iau_in_if.sink           i_in,
    iau_out_if.source        o_out
);
    import iau_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;
    logic    out_valid;

    iau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    iau_dp #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_command   (i_in.command),
        .i_a_low     (i_in.a_low),
        .i_a_high    (i_in.a_high),
        .i_a_empty   (i_in.a_empty),
        .i_b_low     (i_in.b_low),
        .i_b_high    (i_in.b_high),
        .i_b_empty   (i_in.b_empty),
        .i_exponent  (i_in.exponent),
        .o_res_low   (o_out.res_low),
        .o_res_high  (o_out.res_high),
        .o_res_empty (o_out.res_empty),
        .o_overflow  (o_out.overflow)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// ===== tb/tb_interval_arithmetic_unit.sv =====
// Testbench for the interval arithmetic unit: directed and random items, built-in predictor.
`timescale 1ns / 100ps

module tb_interval_arithmetic_unit;
    import iau_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_EXPONENT = 15;
    localparam int ONE_Q        = 1 << FRAC_BITS;
    localparam int QMAX         = 32'sh7fff_ffff;
    localparam int QMIN         = 32'sh8000_0000;
    localparam longint SAT_HI   = 64'sd2147483647;
    localparam longint SAT_LO   = -64'sd2147483648;
    localparam int DRAIN_CYCLES = 200;
    localparam longint TIMEOUT_NS = 64'd8_000_000;

    typedef struct {
        bit signed [Q_W-1:0] res_low;
        bit signed [Q_W-1:0] res_high;
        bit                  res_empty;
        bit                  overflow;
    } t_interval_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iau_in_if  in_ch ();
    iau_out_if out_ch ();

    t_interval_res pending_intervals[$];
    int            n_mismatch = 0;
    int            burst_left = 0;

    interval_arithmetic_unit #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_EXPONENT (MAX_EXPONENT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clamp_q(input longint x, inout bit ovf);
        if (x > SAT_HI) begin
            ovf = 1'b1;
            return SAT_HI;
        end
        if (x < SAT_LO) begin
            ovf = 1'b1;
            return SAT_LO;
        end
        return x;
    endfunction

    // Hull of the four bound products, rounded outward, then saturated.
    function automatic void mul_hull(input longint xl, input longint xh, input longint yl,
                                     input longint yh, output longint rl, output longint rh,
                                     inout bit ovf);
        longint p[4];
        longint mn;
        longint mx;
        p[0] = xl * yl;
        p[1] = xl * yh;
        p[2] = xh * yl;
        p[3] = xh * yh;
        mn = p[0];
        mx = p[0];
        for (int i = 1; i < 4; i++) begin
            if (p[i] < mn) mn = p[i];
            if (p[i] > mx) mx = p[i];
        end
        rl = clamp_q(mn >>> FRAC_BITS, ovf);
        rh = clamp_q(-((-mx) >>> FRAC_BITS), ovf);
    endfunction

    function automatic t_interval_res predict_interval(
        input t_cmd cmd,
        input bit signed [Q_W-1:0] al, input bit signed [Q_W-1:0] ah, input bit ae,
        input bit signed [Q_W-1:0] bl, input bit signed [Q_W-1:0] bh, input bit be,
        input bit [EXP_W-1:0] e
    );
        longint alo, ahi, blo, bhi, lo, hi, t;
        bit emp;
        bit ovf;
        int k;
        t_interval_res r;
        alo = longint'(al);
        ahi = longint'(ah);
        blo = longint'(bl);
        bhi = longint'(bh);
        // swap reversed bounds
        if (alo > ahi) begin
            t = alo; alo = ahi; ahi = t;
        end
        if (blo > bhi) begin
            t = blo; blo = bhi; bhi = t;
        end
        k = (int'(e) > MAX_EXPONENT) ? MAX_EXPONENT : int'(e);
        emp = 1'b0;
        ovf = 1'b0;
        lo = 0;
        hi = 0;
        case (cmd)
            CMD_ADD: begin
                if (ae || be) emp = 1'b1;
                else begin
                    lo = clamp_q(alo + blo, ovf);
                    hi = clamp_q(ahi + bhi, ovf);
                end
            end
            CMD_SUB: begin
                if (ae || be) emp = 1'b1;
                else begin
                    lo = clamp_q(alo - bhi, ovf);
                    hi = clamp_q(ahi - blo, ovf);
                end
            end
            CMD_MUL: begin
                if (ae || be) emp = 1'b1;
                else mul_hull(alo, ahi, blo, bhi, lo, hi, ovf);
            end
            CMD_MEET: begin
                if (ae || be || alo > bhi || blo > ahi) emp = 1'b1;
                else begin
                    lo = (alo > blo) ? alo : blo;
                    hi = (ahi < bhi) ? ahi : bhi;
                end
            end
            CMD_JOIN: begin
                if (ae && be) emp = 1'b1;
                else if (ae) begin
                    lo = blo; hi = bhi;
                end else if (be) begin
                    lo = alo; hi = ahi;
                end else begin
                    lo = (alo < blo) ? alo : blo;
                    hi = (ahi > bhi) ? ahi : bhi;
                end
            end
            CMD_NEG: begin
                if (ae) emp = 1'b1;
                else begin
                    lo = clamp_q(-ahi, ovf);
                    hi = clamp_q(-alo, ovf);
                end
            end
            CMD_ABS: begin
                if (ae) emp = 1'b1;
                else if (ahi < 0) begin
                    lo = clamp_q(-ahi, ovf);
                    hi = clamp_q(-alo, ovf);
                end else if (alo > 0) begin
                    lo = alo; hi = ahi;
                end else begin
                    lo = 0;
                    hi = clamp_q((-alo > ahi) ? -alo : ahi, ovf);
                end
            end
            default: begin
                if (ae) emp = 1'b1;
                else begin
                    lo = longint'(ONE_Q);
                    hi = longint'(ONE_Q);
                    for (int j = 0; j < k; j++) mul_hull(lo, hi, alo, ahi, lo, hi, ovf);
                end
            end
        endcase
        r.res_empty = emp;
        r.res_low   = emp ? '0 : lo[Q_W-1:0];
        r.res_high  = emp ? '0 : hi[Q_W-1:0];
        r.overflow  = emp ? 1'b0 : ovf;
        return r;
    endfunction

    // Check the oldest pending result, then record the item accepted at this edge.
    always @(posedge i_clk) begin : check_results
        t_interval_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_intervals.size() == 0) begin
                $error("result with no item pending: res_low %0d res_high %0d",
                       out_ch.res_low, out_ch.res_high);
                n_mismatch++;
            end else begin
                want = pending_intervals.pop_front();
                if (out_ch.res_low !== want.res_low) begin
                    $error("res_low: expected %0d, got %0d", want.res_low, out_ch.res_low);
                    n_mismatch++;
                end
                if (out_ch.res_high !== want.res_high) begin
                    $error("res_high: expected %0d, got %0d", want.res_high, out_ch.res_high);
                    n_mismatch++;
                end
                if (out_ch.res_empty !== want.res_empty) begin
                    $error("res_empty: expected %0d, got %0d", want.res_empty, out_ch.res_empty);
                    n_mismatch++;
                end
                if (out_ch.overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, out_ch.overflow);
                    n_mismatch++;
                end
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            pending_intervals.push_back(predict_interval(t_cmd'(in_ch.command),
                in_ch.a_low, in_ch.a_high, in_ch.a_empty,
                in_ch.b_low, in_ch.b_high, in_ch.b_empty, in_ch.exponent));
        end
    end

    // Receiver: pick a new random stall pattern whenever the current one runs out.
    initial begin : result_stalls
        int mode;
        int mode_left;
        int cyc;
        mode = 0;
        mode_left = 0;
        cyc = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 1) != 0);
                default: out_ch.ready <= ((cyc % 7) < 2);
            endcase
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // Call at a rising edge; returns at the edge that accepts the item, valid still high.
    task automatic send_item(input t_cmd cmd,
                             input bit signed [Q_W-1:0] al, input bit signed [Q_W-1:0] ah,
                             input bit ae,
                             input bit signed [Q_W-1:0] bl, input bit signed [Q_W-1:0] bh,
                             input bit be, input bit [EXP_W-1:0] e);
        in_ch.valid    <= 1'b1;
        in_ch.command  <= cmd;
        in_ch.a_low    <= al;
        in_ch.a_high   <= ah;
        in_ch.a_empty  <= ae;
        in_ch.b_low    <= bl;
        in_ch.b_high   <= bh;
        in_ch.b_empty  <= be;
        in_ch.exponent <= e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // End a burst with a random gap.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    function automatic bit signed [Q_W-1:0] rand_q(input bit near_one);
        if (near_one) return int'($urandom_range(0, 3 * ONE_Q)) - (3 * ONE_Q) / 2;
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5, 6: return int'($urandom_range(0, 8 * ONE_Q)) - 4 * ONE_Q;
            7: begin
                case ($urandom_range(0, 6))
                    0: return QMIN;
                    1: return QMAX;
                    2: return 0;
                    3: return 1;
                    4: return -1;
                    5: return ONE_Q;
                    default: return -ONE_Q;
                endcase
            end
            8: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
            default: return ONE_Q + int'($urandom_range(0, 64)) - 32;
        endcase
    endfunction

    task automatic send_random_item();
        t_cmd cmd;
        bit small_a;
        bit [EXP_W-1:0] e;
        cmd = t_cmd'($urandom_range(0, 7));
        // keep most power bases within -1.5 to 1.5 so the result does not just saturate
        small_a = (cmd == CMD_POW) && ($urandom_range(0, 3) != 0);
        if (cmd == CMD_POW && $urandom_range(0, 3) != 0) e = EXP_W'($urandom_range(0, 4));
        else e = EXP_W'($urandom_range(0, 15));
        send_item(cmd, rand_q(small_a), rand_q(small_a), $urandom_range(0, 7) == 0,
                  rand_q(1'b0), rand_q(1'b0), $urandom_range(0, 7) == 0, e);
    endtask

    task automatic reset_dut();
        in_ch.valid    <= 1'b0;
        in_ch.command  <= CMD_ADD;
        in_ch.a_low    <= '0;
        in_ch.a_high   <= '0;
        in_ch.a_empty  <= 1'b0;
        in_ch.b_low    <= '0;
        in_ch.b_high   <= '0;
        in_ch.b_empty  <= 1'b0;
        in_ch.exponent <= '0;
        i_rst_n        <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_directed();
        send_item(CMD_ADD, ONE_Q, 2 * ONE_Q, 1'b0, 3 * ONE_Q, 4 * ONE_Q, 1'b0, 4'd0);
        send_item(CMD_ADD, 0, QMAX, 1'b0, 1, QMAX, 1'b0, 4'd0);
        send_item(CMD_SUB, QMIN, 0, 1'b0, 0, 1, 1'b0, 4'd0);
        send_item(CMD_MUL, 2 * ONE_Q, -3 * ONE_Q, 1'b0, -(ONE_Q + ONE_Q / 2), ONE_Q / 2,
                  1'b0, 4'd0);
        send_item(CMD_MUL, -3, 5, 1'b0, 7, 7, 1'b0, 4'd0);
        send_item(CMD_MUL, QMIN, QMAX, 1'b0, QMAX, QMIN, 1'b0, 4'd0);
        send_item(CMD_MUL, ONE_Q, ONE_Q, 1'b1, ONE_Q, ONE_Q, 1'b0, 4'd0);
        send_item(CMD_MEET, -ONE_Q, 2 * ONE_Q, 1'b0, ONE_Q, 5 * ONE_Q, 1'b0, 4'd0);
        send_item(CMD_MEET, -2 * ONE_Q, -ONE_Q, 1'b0, ONE_Q, 5 * ONE_Q, 1'b0, 4'd0);
        send_item(CMD_MEET, QMIN, QMAX, 1'b0, 0, 0, 1'b1, 4'd0);
        send_item(CMD_JOIN, 7, 9, 1'b1, 3 * ONE_Q, -ONE_Q, 1'b0, 4'd0);
        send_item(CMD_JOIN, -ONE_Q, ONE_Q, 1'b0, QMAX, QMIN, 1'b1, 4'd0);
        send_item(CMD_JOIN, ONE_Q, 2, 1'b1, 3, 4, 1'b1, 4'd0);
        send_item(CMD_JOIN, QMIN, 0, 1'b0, 0, QMAX, 1'b0, 4'd0);
        send_item(CMD_NEG, QMIN, 5, 1'b0, 1, 2, 1'b0, 4'd0);
        send_item(CMD_NEG, ONE_Q, 2 * ONE_Q, 1'b1, 0, 0, 1'b0, 4'd0);
        send_item(CMD_ABS, -3 * ONE_Q, -ONE_Q, 1'b0, QMIN, QMAX, 1'b0, 4'd0);
        send_item(CMD_ABS, ONE_Q, 2 * ONE_Q, 1'b0, 0, 0, 1'b1, 4'd0);
        send_item(CMD_ABS, -5 * ONE_Q, 2 * ONE_Q, 1'b0, 0, 0, 1'b0, 4'd0);
        send_item(CMD_ABS, QMIN, QMIN, 1'b0, 0, 0, 1'b0, 4'd0);
        send_item(CMD_POW, -7 * ONE_Q, 3 * ONE_Q, 1'b0, 0, 0, 1'b0, 4'd0);
        send_item(CMD_POW, ONE_Q, ONE_Q, 1'b1, 0, 0, 1'b0, 4'd0);
        send_item(CMD_POW, -2 * ONE_Q, 3 * ONE_Q, 1'b0, 0, 0, 1'b0, 4'd15);
        send_item(CMD_POW, -ONE_Q / 2, 3 * ONE_Q / 4, 1'b0, QMAX, QMIN, 1'b1, 4'd3);
        send_item(CMD_ADD, ONE_Q, ONE_Q, 1'b0, QMIN, QMAX, 1'b1, 4'd9);
    endtask

    task automatic test_random_bursts(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            send_random_item();
            pace_sender();
        end
    endtask

    task automatic test_random_streaming(input int n_items);
        for (int i = 0; i < n_items; i++) send_random_item();
    endtask

    initial begin
        reset_dut();
        test_directed();
        test_random_bursts(800);
        test_random_streaming(400);
        in_ch.valid <= 1'b0;
        while (pending_intervals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/iau_pkg.sv
design/iau_if.sv
design/iau_ctrl.sv
design/iau_dp.sv
design/interval_arithmetic_unit.sv
tb/tb_interval_arithmetic_unit.sv
